// ===== src/vscs_pkg.sv =====
`default_nettype none

package vscs_pkg;

    // Width of the byte counter; the counter saturates at its all-ones value.
    localparam int POSITION_BITS = 24;
    // Width of the reported position field.
    localparam int POS_OUT_BITS  = 24;

    localparam logic [POSITION_BITS-1:0] POS_LIMIT = {POSITION_BITS{1'b1}};

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCAN_BACKWARD = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLASS_MASK    = 2'd1;

    localparam logic [7:0] CLASS_MASK_RESET = 8'hFF;

    // Byte machine states. Their meaning depends on the scan direction.
    localparam logic [1:0] ST_START = 2'd0;
    localparam logic [1:0] ST_ONE   = 2'd1;
    localparam logic [1:0] ST_TWO   = 2'd2;
    localparam logic [1:0] ST_CODE  = 2'd3;

    // Start code prefix 00 00 01 as it sits in the byte window.
    localparam logic [23:0] PREFIX = 24'h000001;

    // Start code class values.
    localparam logic [7:0] CLASS_NONE        = 8'h00;
    localparam logic [7:0] CLASS_PICTURE     = 8'h04;
    localparam logic [7:0] CLASS_FIRST_SLICE = 8'h03;
    localparam logic [7:0] CLASS_SLICE       = 8'h01;
    localparam logic [7:0] CLASS_USER_DATA   = 8'h20;
    localparam logic [7:0] CLASS_SEQ_HEADER  = 8'h40;
    localparam logic [7:0] CLASS_EXTENSION   = 8'h10;
    localparam logic [7:0] CLASS_SEQ_END     = 8'h80;
    localparam logic [7:0] CLASS_GOP         = 8'h08;

    // Start code values (the byte after the 00 00 01 prefix).
    localparam logic [7:0] SC_PICTURE     = 8'h00;
    localparam logic [7:0] SC_FIRST_SLICE = 8'h01;
    localparam logic [7:0] SC_SLICE_LO    = 8'h02;
    localparam logic [7:0] SC_SLICE_HI    = 8'hAF;
    localparam logic [7:0] SC_USER_DATA   = 8'hB2;
    localparam logic [7:0] SC_SEQ_HEADER  = 8'hB3;
    localparam logic [7:0] SC_EXTENSION   = 8'hB5;
    localparam logic [7:0] SC_SEQ_END     = 8'hB7;
    localparam logic [7:0] SC_GOP         = 8'hB8;

    // One result item.
    typedef struct packed {
        logic                    found;
        logic [POS_OUT_BITS-1:0] position;
        logic [7:0]              code_class;
        logic [7:0]              code_byte;
    } vscs_result_t;

    // Class of a start code whose prefix has already been checked.
    function automatic logic [7:0] classify(input logic [7:0] code);
        logic [7:0] cls;
        case (code) inside
            SC_PICTURE:                 cls = CLASS_PICTURE;
            SC_FIRST_SLICE:             cls = CLASS_FIRST_SLICE;
            [SC_SLICE_LO:SC_SLICE_HI]:  cls = CLASS_SLICE;
            SC_USER_DATA:               cls = CLASS_USER_DATA;
            SC_SEQ_HEADER:              cls = CLASS_SEQ_HEADER;
            SC_EXTENSION:               cls = CLASS_EXTENSION;
            SC_SEQ_END:                 cls = CLASS_SEQ_END;
            SC_GOP:                     cls = CLASS_GOP;
            default:                    cls = CLASS_NONE;
        endcase
        return cls;
    endfunction

endpackage

`default_nettype wire

// ===== src/vscs_if.sv =====
`default_nettype none

// Byte stream channel.
interface vscs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result channel.
interface vscs_result_if;
    logic                              valid;
    logic                              ready;
    logic                              found;
    logic [vscs_pkg::POS_OUT_BITS-1:0] position;
    logic [7:0]                        code_class;
    logic [7:0]                        code_byte;

    modport source (output valid, output found, output position, output code_class,
                    output code_byte, input ready);
    modport sink   (input valid, input found, input position, input code_class,
                    input code_byte, output ready);
endinterface

// Configuration write channel.
interface vscs_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [vscs_pkg::CFG_INDEX_BITS-1:0] index;
    logic [7:0]                          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/video_start_code_search_core.sv =====
`default_nettype none

// Start code search core: scans a byte stream for MPEG video start codes
// (00 00 01 xx), forward or backward as the scan_backward register selects,
// and reports the first code whose class bit is set in class_mask, with its
// position, or a not-found item on the buffer's last byte. The core takes one
// byte per clock cycle; each byte is handled in the cycle it is accepted and
// its result, if any, appears in the output register on the next cycle. The
// only thing that holds off input is that output register: ready drops only
// while it holds an item that the sink has not yet taken. Bytes after a match
// are consumed without a result until the last byte, which rearms the core.
// Configuration writes are always taken and must be made while the core idles.
module video_start_code_search_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    vscs_byte_if.sink          stream,
    vscs_result_if.source      result,
    vscs_cfg_if.sink           cfg
);

    // Configuration registers.
    logic       scan_backward_reg;
    logic [7:0] class_mask_reg;

    // Scanner state.
    logic [1:0]                            scan_state_reg;
    logic [1:0]                            scan_state_next;
    logic [23:0]                           byte_window_reg;
    logic [vscs_pkg::POSITION_BITS-1:0]    byte_count_reg;
    logic                                  match_done_reg;

    // Output register.
    logic                   out_valid_reg;
    vscs_pkg::vscs_result_t out_reg;
    vscs_pkg::vscs_result_t out_next;

    logic                                accept;
    logic                                hit;
    logic [7:0]                          hit_class;
    logic [7:0]                          code_byte;
    logic [vscs_pkg::POS_OUT_BITS-1:0]   hit_pos;
    logic                                emit;
    logic                                count_sat;

    assign accept       = stream.valid && stream.ready;
    assign stream.ready = !out_valid_reg || result.ready;
    assign cfg.ready    = 1'b1;
    assign count_sat    = (byte_count_reg == vscs_pkg::POS_LIMIT);

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_backward_reg <= 1'b0;
            class_mask_reg    <= vscs_pkg::CLASS_MASK_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == vscs_pkg::REG_SCAN_BACKWARD)
            begin
                scan_backward_reg <= cfg.data[0];
            end
            else if (cfg.index == vscs_pkg::REG_CLASS_MASK)
            begin
                class_mask_reg <= cfg.data;
            end
        end
    end

    // Byte machine for both directions and the match check.
    always_comb
    begin
        scan_state_next = scan_state_reg;
        hit_class       = vscs_pkg::CLASS_NONE;
        code_byte       = stream.data_byte;
        hit_pos         = '0;
        if (!scan_backward_reg)
        begin
            case (scan_state_reg)
                vscs_pkg::ST_START:
                begin
                    if (stream.data_byte == 8'h00)
                    begin
                        scan_state_next = vscs_pkg::ST_ONE;
                    end
                end
                vscs_pkg::ST_ONE:
                begin
                    scan_state_next = (stream.data_byte == 8'h00) ? vscs_pkg::ST_TWO
                                                                 : vscs_pkg::ST_START;
                end
                vscs_pkg::ST_TWO:
                begin
                    if (stream.data_byte == 8'h01)
                    begin
                        scan_state_next = vscs_pkg::ST_CODE;
                    end
                    else if (stream.data_byte != 8'h00)
                    begin
                        scan_state_next = vscs_pkg::ST_START;
                    end
                end
                default:
                begin
                    // The window holds the three bytes before this one.
                    if (byte_window_reg == vscs_pkg::PREFIX)
                    begin
                        hit_class = vscs_pkg::classify(stream.data_byte);
                    end
                    code_byte       = stream.data_byte;
                    hit_pos         = count_sat
                                    ? vscs_pkg::POS_OUT_BITS'(vscs_pkg::POS_LIMIT)
                                    : vscs_pkg::POS_OUT_BITS'(byte_count_reg)
                                      - vscs_pkg::POS_OUT_BITS'(3);
                    scan_state_next = vscs_pkg::ST_START;
                end
            endcase
        end
        else
        begin
            case (scan_state_reg)
                vscs_pkg::ST_START:
                begin
                    scan_state_next = vscs_pkg::ST_ONE;
                end
                vscs_pkg::ST_ONE:
                begin
                    if (stream.data_byte == 8'h01)
                    begin
                        scan_state_next = vscs_pkg::ST_TWO;
                    end
                end
                vscs_pkg::ST_TWO:
                begin
                    if (stream.data_byte == 8'h00)
                    begin
                        scan_state_next = vscs_pkg::ST_CODE;
                    end
                    else if (stream.data_byte != 8'h01)
                    begin
                        scan_state_next = vscs_pkg::ST_ONE;
                    end
                end
                default:
                begin
                    // Read in memory order: this byte, then the window newest first.
                    code_byte = byte_window_reg[23:16];
                    hit_pos   = count_sat
                              ? vscs_pkg::POS_OUT_BITS'(vscs_pkg::POS_LIMIT)
                              : vscs_pkg::POS_OUT_BITS'(byte_count_reg + 1'b1);
                    if (stream.data_byte == 8'h00)
                    begin
                        if (byte_window_reg[7:0] == 8'h00 && byte_window_reg[15:8] == 8'h01)
                        begin
                            hit_class = vscs_pkg::classify(byte_window_reg[23:16]);
                        end
                        scan_state_next = vscs_pkg::ST_START;
                    end
                    else if (stream.data_byte != 8'h01)
                    begin
                        scan_state_next = vscs_pkg::ST_ONE;
                    end
                    else
                    begin
                        scan_state_next = vscs_pkg::ST_TWO;
                    end
                end
            endcase
        end
    end

    assign hit  = (hit_class & class_mask_reg) != 8'h00;
    assign emit = !match_done_reg && (hit || stream.last_byte);

    // Result item for this byte.
    always_comb
    begin
        if (hit)
        begin
            out_next.found      = 1'b1;
            out_next.position   = hit_pos;
            out_next.code_class = hit_class;
            out_next.code_byte  = code_byte;
        end
        else
        begin
            out_next = '0;
        end
    end

    // Scanner state update; the last byte of a buffer rearms the scanner.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_state_reg  <= vscs_pkg::ST_START;
            byte_window_reg <= '0;
            byte_count_reg  <= '0;
            match_done_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (stream.last_byte)
            begin
                scan_state_reg  <= vscs_pkg::ST_START;
                byte_window_reg <= '0;
                byte_count_reg  <= '0;
                match_done_reg  <= 1'b0;
            end
            else if (!match_done_reg)
            begin
                scan_state_reg  <= scan_state_next;
                byte_window_reg <= {byte_window_reg[15:0], stream.data_byte};
                if (!count_sat)
                begin
                    byte_count_reg <= byte_count_reg + 1'b1;
                end
                match_done_reg <= hit;
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.found      = out_reg.found;
    assign result.position   = out_reg.position;
    assign result.code_class = out_reg.code_class;
    assign result.code_byte  = out_reg.code_byte;

    // A not-found item carries all-zero fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.found) |->
        (out_reg.position == '0 && out_reg.code_class == 8'h00 && out_reg.code_byte == 8'h00))
    else $error("not-found item with nonzero fields");

    // A found item has a class that the mask accepts.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.found) |-> ((out_reg.code_class & class_mask_reg) != 8'h00))
    else $error("found item with a masked class");

    // The last byte of a buffer leaves the scanner rearmed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && stream.last_byte) |=>
        (scan_state_reg == vscs_pkg::ST_START && byte_count_reg == '0 && !match_done_reg))
    else $error("scanner not rearmed after last byte");

    // The match flag rises only together with a found item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(match_done_reg) |-> (out_valid_reg && out_reg.found))
    else $error("match flag set without a found item");

    // An item is never accepted while an untaken result blocks the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !accept)
    else $error("item accepted while output register is full");

endmodule

`default_nettype wire
